// ----- design/lpg_pkg.sv -----
`default_nettype none

package lpg_pkg;

   // default coordinate width; the top level can override it
   localparam int COORD_BITS_DEF = 12;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [31:0] FRAME_BASE_RST      = 32'd0;
   localparam logic [15:0] ROW_PITCH_RST       = 16'd1600;
   localparam logic [2:0]  BYTES_PER_PIXEL_RST = 3'd2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_BASE      = 2'd0,
      CSR_ROW_PITCH       = 2'd1,
      CSR_BYTES_PER_PIXEL = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } opcode_type;

   typedef struct packed {
      logic [31:0] frame_base;
      logic [15:0] row_pitch;
      logic [2:0]  bytes_per_pixel;
   } cfg_type;

endpackage

`default_nettype wire

// ----- design/line_pixel_generator.sv -----
// line_pixel_generator: Bresenham line walker with framebuffer byte addressing.
// Request channel (req_*): tuser is the opcode, 0 starts a line, 1 advances it.
//   A start request latches both endpoints and the color and yields the first
//   pixel; each advance request yields the next pixel along the major axis.
// Response channel (rsp_*): one response per request. tuser is 1 for a real
//   pixel, 0 for an advance with no line running (all fields zero then).
//   tlast marks the endpoint pixel, after which the walker is idle again.
// Address = frame_base + y*row_pitch + x*bytes_per_pixel, modulo 2^32.
// Config channel (csr_*): always ready; index 0 frame_base, 1 row_pitch,
//   2 bytes_per_pixel. Write only while no request is in flight.
// Throughput: one request per clock while the response side does not stall.
//   The walker register updates all line state at once, so back-to-back advances need no gaps.
// Pipeline: three register stages (walker register, multiply register, address
//   add into the output register).
// Stall: each stage holds when the next is full; bubbles are squeezed out, so
//   requests keep being taken while a response waits, up to three in flight.
// Reset: drops any line in progress, empties the pipeline and restores
//   frame_base 0, row_pitch 1600, bytes_per_pixel 2.
`default_nettype none

module line_pixel_generator #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      req_tvalid,
   output logic                                     req_tready,
   // start_x, start_y, end_x, end_y, color; zero padded to bytes
   input  wire  [((4*COORD_BITS+32+7)/8)*8-1:0]     req_tdata,
   // opcode
   input  wire                                      req_tuser,
   output logic                                     rsp_tvalid,
   input  wire                                      rsp_tready,
   // pixel_x, pixel_y, pixel_color, byte_address; zero padded to bytes
   output logic [((2*COORD_BITS+64+7)/8)*8-1:0]     rsp_tdata,
   // valid_res
   output logic                                     rsp_tuser,
   output logic                                     rsp_tlast,
   input  wire                                      csr_valid,
   output logic                                     csr_ready,
   input  wire  [lpg_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  wire  [lpg_pkg::CSR_DATA_BITS-1:0]        csr_wdata
);
   import lpg_pkg::*;

   localparam int RSP_BITS = ((2*COORD_BITS+64+7)/8)*8;

   cfg_type                cfg;

   logic                   pix_valid, pix_ready, pix_hit, pix_last;
   logic [COORD_BITS-1:0]  pix_x, pix_y;
   logic [31:0]            pix_color;

   logic                   rsp_hit, rsp_last;
   logic [COORD_BITS-1:0]  rsp_x, rsp_y;
   logic [31:0]            rsp_color, rsp_address;

   lpg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lpg_walker #(.COORD_BITS(COORD_BITS)) u_walker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_opcode (req_tuser),
      .start_x    (req_tdata[COORD_BITS-1:0]),
      .start_y    (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .end_x      (req_tdata[3*COORD_BITS-1:2*COORD_BITS]),
      .end_y      (req_tdata[4*COORD_BITS-1:3*COORD_BITS]),
      .color      (req_tdata[4*COORD_BITS+31:4*COORD_BITS]),
      .pix_valid  (pix_valid),
      .pix_ready  (pix_ready),
      .pix_hit    (pix_hit),
      .pix_x      (pix_x),
      .pix_y      (pix_y),
      .pix_color  (pix_color),
      .pix_last   (pix_last)
   );

   lpg_addr #(.COORD_BITS(COORD_BITS)) u_addr (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .pix_valid   (pix_valid),
      .pix_ready   (pix_ready),
      .pix_hit     (pix_hit),
      .pix_x       (pix_x),
      .pix_y       (pix_y),
      .pix_color   (pix_color),
      .pix_last    (pix_last),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_hit     (rsp_hit),
      .rsp_x       (rsp_x),
      .rsp_y       (rsp_y),
      .rsp_color   (rsp_color),
      .rsp_address (rsp_address),
      .rsp_last    (rsp_last)
   );

   assign rsp_tdata = RSP_BITS'({rsp_address, rsp_color, rsp_y, rsp_x});
   assign rsp_tuser = rsp_hit;
   assign rsp_tlast = rsp_last;

endmodule

`default_nettype wire

// ----- design/lpg_csr.sv -----
`default_nettype none

module lpg_csr (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [lpg_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire  [lpg_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output lpg_pkg::cfg_type                    cfg
);
   import lpg_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_BASE:      cfg_in.frame_base      = csr_wdata[31:0];
            CSR_ROW_PITCH:       cfg_in.row_pitch       = csr_wdata[15:0];
            CSR_BYTES_PER_PIXEL: cfg_in.bytes_per_pixel = csr_wdata[2:0];
            default:             cfg_in = cfg_ff;   // unmapped index, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_base      <= FRAME_BASE_RST;
         cfg_ff.row_pitch       <= ROW_PITCH_RST;
         cfg_ff.bytes_per_pixel <= BYTES_PER_PIXEL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/lpg_walker.sv -----
`default_nettype none

module lpg_walker #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire                    req_opcode,
   input  wire  [COORD_BITS-1:0]  start_x,
   input  wire  [COORD_BITS-1:0]  start_y,
   input  wire  [COORD_BITS-1:0]  end_x,
   input  wire  [COORD_BITS-1:0]  end_y,
   input  wire  [31:0]            color,
   output logic                   pix_valid,
   input  wire                    pix_ready,
   output logic                   pix_hit,
   output logic [COORD_BITS-1:0]  pix_x,
   output logic [COORD_BITS-1:0]  pix_y,
   output logic [31:0]            pix_color,
   output logic                   pix_last
);
   import lpg_pkg::*;

   // error term spans about +-2^(COORD_BITS+1)
   localparam int ERR_BITS = COORD_BITS + 3;

   logic                   busy_ff, busy_in;
   logic [COORD_BITS-1:0]  cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0]  stop_x_ff, stop_x_in, stop_y_ff, stop_y_in;
   logic                   dir_x_neg_ff, dir_x_neg_in, dir_y_neg_ff, dir_y_neg_in;
   logic                   x_major_ff, x_major_in;
   logic [COORD_BITS:0]    twice_dx_ff, twice_dx_in, twice_dy_ff, twice_dy_in;
   logic [ERR_BITS-1:0]    error_ff, error_in;
   logic [31:0]            color_ff, color_in;

   logic                   pix_valid_ff, pix_valid_in;
   logic                   pix_hit_ff, pix_hit_in, pix_last_ff, pix_last_in;
   logic [COORD_BITS-1:0]  pix_x_ff, pix_x_in, pix_y_ff, pix_y_in;
   logic [31:0]            pix_color_ff, pix_color_in;

   logic                   accept;

   // line setup
   logic [COORD_BITS:0]    diff_x, diff_y, mag_x, mag_y;
   logic [COORD_BITS-1:0]  abs_x, abs_y;
   logic                   st_x_major, st_done;
   logic [ERR_BITS-1:0]    st_err;

   // one step
   logic [COORD_BITS-1:0]  step_x, step_y, nx, ny;
   logic [ERR_BITS-1:0]    tdx_ext, tdy_ext, nerr;
   logic                   minor, sd;

   assign req_ready = !pix_valid_ff || pix_ready;
   assign accept    = req_valid && req_ready;

   assign diff_x = {1'b0, end_x} - {1'b0, start_x};
   assign diff_y = {1'b0, end_y} - {1'b0, start_y};
   assign mag_x  = diff_x[COORD_BITS] ? (~diff_x + 1'b1) : diff_x;
   assign mag_y  = diff_y[COORD_BITS] ? (~diff_y + 1'b1) : diff_y;
   assign abs_x  = mag_x[COORD_BITS-1:0];
   assign abs_y  = mag_y[COORD_BITS-1:0];
   assign st_x_major = abs_x > abs_y;   // ties go to y
   assign st_err = st_x_major ? ({2'b00, abs_y, 1'b0} - {3'b000, abs_x})
                              : ({2'b00, abs_x, 1'b0} - {3'b000, abs_y});
   assign st_done = st_x_major ? (start_x == end_x) : (start_y == end_y);

   assign step_x  = dir_x_neg_ff ? (cur_x_ff - 1'b1) : (cur_x_ff + 1'b1);
   assign step_y  = dir_y_neg_ff ? (cur_y_ff - 1'b1) : (cur_y_ff + 1'b1);
   assign tdx_ext = {2'b00, twice_dx_ff};
   assign tdy_ext = {2'b00, twice_dy_ff};
   assign minor   = !error_ff[ERR_BITS-1];

   always_comb begin
      if (x_major_ff) begin
         nx   = step_x;
         ny   = minor ? step_y : cur_y_ff;
         nerr = error_ff - (minor ? tdx_ext : '0) + tdy_ext;
         sd   = (step_x == stop_x_ff);
      end else begin
         nx   = minor ? step_x : cur_x_ff;
         ny   = step_y;
         nerr = error_ff - (minor ? tdy_ext : '0) + tdx_ext;
         sd   = (step_y == stop_y_ff);
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      stop_x_in    = stop_x_ff;
      stop_y_in    = stop_y_ff;
      dir_x_neg_in = dir_x_neg_ff;
      dir_y_neg_in = dir_y_neg_ff;
      x_major_in   = x_major_ff;
      twice_dx_in  = twice_dx_ff;
      twice_dy_in  = twice_dy_ff;
      error_in     = error_ff;
      color_in     = color_ff;
      pix_valid_in = pix_valid_ff && !pix_ready;
      pix_hit_in   = pix_hit_ff;
      pix_x_in     = pix_x_ff;
      pix_y_in     = pix_y_ff;
      pix_color_in = pix_color_ff;
      pix_last_in  = pix_last_ff;
      if (accept) begin
         pix_valid_in = 1'b1;
         priority if (req_opcode == OP_START) begin
            cur_x_in     = start_x;
            cur_y_in     = start_y;
            stop_x_in    = end_x;
            stop_y_in    = end_y;
            dir_x_neg_in = diff_x[COORD_BITS];
            dir_y_neg_in = diff_y[COORD_BITS];
            x_major_in   = st_x_major;
            twice_dx_in  = {abs_x, 1'b0};
            twice_dy_in  = {abs_y, 1'b0};
            error_in     = st_err;
            color_in     = color;
            busy_in      = !st_done;
            pix_hit_in   = 1'b1;
            pix_x_in     = start_x;
            pix_y_in     = start_y;
            pix_color_in = color;
            pix_last_in  = st_done;
         end else if (busy_ff) begin
            cur_x_in     = nx;
            cur_y_in     = ny;
            error_in     = nerr;
            busy_in      = !sd;
            pix_hit_in   = 1'b1;
            pix_x_in     = nx;
            pix_y_in     = ny;
            pix_color_in = color_ff;
            pix_last_in  = sd;
         end else begin
            // step with no line in progress: empty result
            pix_hit_in   = 1'b0;
            pix_x_in     = '0;
            pix_y_in     = '0;
            pix_color_in = '0;
            pix_last_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pix_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pix_valid_ff <= pix_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      stop_x_ff    <= stop_x_in;
      stop_y_ff    <= stop_y_in;
      dir_x_neg_ff <= dir_x_neg_in;
      dir_y_neg_ff <= dir_y_neg_in;
      x_major_ff   <= x_major_in;
      twice_dx_ff  <= twice_dx_in;
      twice_dy_ff  <= twice_dy_in;
      error_ff     <= error_in;
      color_ff     <= color_in;
      pix_hit_ff   <= pix_hit_in;
      pix_x_ff     <= pix_x_in;
      pix_y_ff     <= pix_y_in;
      pix_color_ff <= pix_color_in;
      pix_last_ff  <= pix_last_in;
   end

   assign pix_valid = pix_valid_ff;
   assign pix_hit   = pix_hit_ff;
   assign pix_x     = pix_x_ff;
   assign pix_y     = pix_y_ff;
   assign pix_color = pix_color_ff;
   assign pix_last  = pix_last_ff;

   a_accept_fills : assert property (@(posedge clock) disable iff (reset)
      accept |=> pix_valid_ff)
      else $error("accepted request did not produce a pixel record");

   a_idle_step_keeps_idle : assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == OP_STEP && !busy_ff) |=> (!busy_ff && !pix_hit_ff))
      else $error("step while idle changed walker state");

   a_last_ends_line : assert property (@(posedge clock) disable iff (reset)
      (pix_valid_ff && pix_hit_ff && pix_last_ff) |-> !busy_ff)
      else $error("endpoint emitted but walker still busy");

   a_idle_zero : assert property (@(posedge clock) disable iff (reset)
      (pix_valid_ff && !pix_hit_ff) |-> (pix_x_ff == '0 && pix_y_ff == '0 &&
                                         pix_color_ff == '0 && !pix_last_ff))
      else $error("empty result carries nonzero fields");

endmodule

`default_nettype wire

// ----- design/lpg_addr.sv -----
`default_nettype none

module lpg_addr #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  lpg_pkg::cfg_type       cfg,
   input  wire                    pix_valid,
   output logic                   pix_ready,
   input  wire                    pix_hit,
   input  wire  [COORD_BITS-1:0]  pix_x,
   input  wire  [COORD_BITS-1:0]  pix_y,
   input  wire  [31:0]            pix_color,
   input  wire                    pix_last,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output logic                   rsp_hit,
   output logic [COORD_BITS-1:0]  rsp_x,
   output logic [COORD_BITS-1:0]  rsp_y,
   output logic [31:0]            rsp_color,
   output logic [31:0]            rsp_address,
   output logic                   rsp_last
);
   import lpg_pkg::*;

   localparam int YPROD_BITS = COORD_BITS + 16;
   localparam int XPROD_BITS = COORD_BITS + 3;

   // multiply stage
   logic                   m_valid_ff, m_valid_in;
   logic                   m_hit_ff, m_last_ff;
   logic [COORD_BITS-1:0]  m_x_ff, m_y_ff;
   logic [31:0]            m_color_ff;
   logic [YPROD_BITS-1:0]  m_yprod_ff, yprod;
   logic [XPROD_BITS-1:0]  m_xprod_ff, xprod;

   // output stage
   logic                   o_valid_ff, o_valid_in;
   logic                   o_hit_ff, o_last_ff;
   logic [COORD_BITS-1:0]  o_x_ff, o_y_ff;
   logic [31:0]            o_color_ff, o_addr_ff, addr_sum;

   logic                   o_ready, m_load, o_load;

   assign o_ready   = !o_valid_ff || rsp_ready;
   assign pix_ready = !m_valid_ff || o_ready;
   assign m_load    = pix_valid && pix_ready;
   assign o_load    = m_valid_ff && o_ready;

   assign yprod    = pix_y * cfg.row_pitch;
   assign xprod    = pix_x * cfg.bytes_per_pixel;
   assign addr_sum = cfg.frame_base + 32'(m_yprod_ff) + 32'(m_xprod_ff);

   assign m_valid_in = pix_ready ? pix_valid : m_valid_ff;
   assign o_valid_in = o_ready ? m_valid_ff : o_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= m_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (m_load) begin
         m_hit_ff   <= pix_hit;
         m_last_ff  <= pix_last;
         m_x_ff     <= pix_x;
         m_y_ff     <= pix_y;
         m_color_ff <= pix_color;
         m_yprod_ff <= yprod;
         m_xprod_ff <= xprod;
      end
      if (o_load) begin
         o_hit_ff   <= m_hit_ff;
         o_last_ff  <= m_last_ff;
         o_x_ff     <= m_x_ff;
         o_y_ff     <= m_y_ff;
         o_color_ff <= m_color_ff;
         o_addr_ff  <= m_hit_ff ? addr_sum : 32'd0;
      end
   end

   assign rsp_valid   = o_valid_ff;
   assign rsp_hit     = o_hit_ff;
   assign rsp_x       = o_x_ff;
   assign rsp_y       = o_y_ff;
   assign rsp_color   = o_color_ff;
   assign rsp_address = o_addr_ff;
   assign rsp_last    = o_last_ff;

   a_pix_to_mult : assert property (@(posedge clock) disable iff (reset)
      m_load |=> m_valid_ff)
      else $error("pixel record lost entering multiply stage");

   a_mult_to_out : assert property (@(posedge clock) disable iff (reset)
      o_load |=> o_valid_ff)
      else $error("pixel record lost entering output stage");

   a_empty_addr : assert property (@(posedge clock) disable iff (reset)
      (o_valid_ff && !o_hit_ff) |-> (o_addr_ff == 32'd0))
      else $error("empty result carries an address");

endmodule

`default_nettype wire
